@@ sv/first_fit_heap_allocator_defines.svh @@
// Assertion macros shared by the heap allocator RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define FFHA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap allocator check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap allocator check failed");

`endif

@@ sv/ffha_pkg.sv @@
// Types, constants and state encoding for the first-fit heap allocator.
package ffha_pkg;

    localparam int HEAP_GRANULES = 1024;
    localparam int GRANULE_BYTES = 16;
    localparam int HEADER_BYTES  = 8;

    localparam int GRAN_LOG2 = $clog2(GRANULE_BYTES);
    localparam int IDX_W     = $clog2(HEAP_GRANULES);
    localparam int SIZE_W    = 11;
    localparam int BYTES_W   = 15;
    localparam int ADDR_W    = 14;
    localparam int NEED_W    = BYTES_W + 1 - GRAN_LOG2;
    localparam int CUR_W     = SIZE_W + 1;

    localparam logic [SIZE_W-1:0] LIMIT_RESET = SIZE_W'(1024);

    localparam logic REQ_ALLOC       = 1'b0;
    localparam logic REQ_FREE        = 1'b1;
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [BYTES_W-1:0] request_bytes;
        logic [ADDR_W-1:0]  free_address;
    } t_req;

    typedef struct packed {
        logic              status;
        logic [ADDR_W-1:0] data_address;
    } t_result;

    // One block header as held in the block store.
    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] size;
    } t_blk;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_ALLOC_CHK,
        S_APPEND,
        S_SPLIT,
        S_FREE_CUR,
        S_FREE_MERGE
    } t_state;

endpackage

@@ sv/first_fit_heap_allocator.sv @@
// First-fit heap allocator: block header store, list walk, split and forward merge.
//
//   Channel   Direction  Handshake                 Payload
//   request   in         start high, busy low      i_req    (t_req)
//   result    out        o_done strobe, one cycle  o_result (t_result)
//   config    in         i_cfg_we, no wait         i_cfg_wdata (heap limit in granules)
//
// An allocate transaction passes through the start state, one check state per block the
// walk visits (none on an empty heap), and a split or append state when it splits a block
// or appends at the heap end. A free transaction reads the freed header, then one header per
// following block merged, and one more when the merge stops at a block that is in use or
// of zero size below the heap end; an invalid free address answers from the start state.
// The walk and the merge are bound by the single read port of the block store: one header
// is read per cycle. busy stays high from acceptance until the result strobe, and a new
// transaction may be started in the strobe cycle.
// Reset is synchronous and active low; it empties the heap and restores the limit to
// 1024 granules. The block store itself is not cleared. The result cannot be stalled.
module first_fit_heap_allocator
    import ffha_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_req              i_req,
    output logic              o_done,
    output t_result           o_result,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata
);

`include "first_fit_heap_allocator_defines.svh"

    // Control registers.
    t_state            r_state, n_state;
    logic [SIZE_W-1:0] r_heap_end, n_heap_end;
    logic [SIZE_W-1:0] r_limit;
    logic              r_done, n_done;

    // Payload registers for the transaction in flight and the result.
    t_req              r_req, n_req;
    logic [NEED_W-1:0] r_need, n_need;
    logic [IDX_W-1:0]  r_g, n_g;
    logic [CUR_W-1:0]  r_cur, n_cur;
    logic [SIZE_W-1:0] r_sz, n_sz;
    logic              r_status, n_status;
    logic [ADDR_W-1:0] r_addr, n_addr;

    // Block header store: one synchronous read port and one write port.
    t_blk              r_mem [HEAP_GRANULES];
    t_blk              r_rd_data;
    logic              w_rd_en;
    logic [IDX_W-1:0]  w_rd_addr;
    logic              w_we;
    logic [IDX_W-1:0]  w_wa;
    t_blk              w_wd;

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
    end

    // Request decode. The granule count includes the header and rounds up.
    logic [NEED_W-1:0]  w_need_in;
    logic [SIZE_W-1:0]  w_eff_limit;
    logic [ADDR_W-1:0]  w_off;
    logic [IDX_W-1:0]   w_fg;
    logic               w_free_ok;

    assign w_need_in = NEED_W'(((BYTES_W + 1)'(i_req.request_bytes)
                       + (BYTES_W + 1)'(HEADER_BYTES + GRANULE_BYTES - 1)) >> GRAN_LOG2);
    assign w_eff_limit = (r_limit < SIZE_W'(HEAP_GRANULES)) ? r_limit
                                                            : SIZE_W'(HEAP_GRANULES);

    // A free address is honored only when it sits at the header offset of a granule
    // that lies inside the heap.
    assign w_off     = r_req.free_address - ADDR_W'(HEADER_BYTES);
    assign w_fg      = w_off[GRAN_LOG2 +: IDX_W];
    assign w_free_ok = (r_req.free_address >= ADDR_W'(HEADER_BYTES))
                    && (w_off[GRAN_LOG2-1:0] == '0)
                    && (SIZE_W'(w_fg) < r_heap_end);

    // Walk decisions on the header that was just read.
    logic                w_fit;
    logic                w_split;
    logic [SIZE_W:0]     w_walk_next;
    logic                w_walk_go;
    logic [NEED_W:0]     w_end_sum;
    logic                w_no_space;
    logic [NEED_W:0]     w_nb;
    logic [ADDR_W-1:0]   w_g_addr;
    logic [ADDR_W-1:0]   w_end_addr;

    assign w_fit       = !r_rd_data.used && (NEED_W'(r_rd_data.size) >= r_need);
    assign w_split     = NEED_W'(r_rd_data.size) > r_need;
    assign w_walk_next = (SIZE_W + 1)'(r_g) + (SIZE_W + 1)'(r_rd_data.size);
    assign w_walk_go   = (r_rd_data.size != '0)
                      && (w_walk_next < (SIZE_W + 1)'(r_heap_end));
    assign w_end_sum   = (NEED_W + 1)'(r_heap_end) + (NEED_W + 1)'(r_need);
    assign w_no_space  = w_end_sum > (NEED_W + 1)'(w_eff_limit);
    assign w_nb        = (NEED_W + 1)'(r_g) + (NEED_W + 1)'(r_need);
    assign w_g_addr    = ADDR_W'({r_g, GRAN_LOG2'(0)}) + ADDR_W'(HEADER_BYTES);
    assign w_end_addr  = ADDR_W'({r_heap_end[IDX_W-1:0], GRAN_LOG2'(0)})
                       + ADDR_W'(HEADER_BYTES);

    // Merge decisions. The first header read is the freed block itself; every later
    // read is the block that directly follows the running size.
    logic                w_merge;
    logic [CUR_W-1:0]    w_cur_new;
    logic [CUR_W:0]      w_nx;
    logic                w_more;

    assign w_merge   = !r_rd_data.used && (r_rd_data.size != '0);
    assign w_cur_new = (r_state == S_FREE_CUR) ? CUR_W'(r_rd_data.size)
                     : (w_merge ? r_cur + CUR_W'(r_rd_data.size) : r_cur);
    assign w_nx      = (CUR_W + 1)'(r_g) + (CUR_W + 1)'(w_cur_new);
    assign w_more    = ((r_state == S_FREE_CUR) ? (r_rd_data.size != '0) : w_merge)
                    && (w_nx < (CUR_W + 1)'(r_heap_end));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (r_req.req_type == REQ_ALLOC) begin
                    n_state = (r_heap_end == '0) ? S_APPEND : S_ALLOC_CHK;
                end else begin
                    n_state = w_free_ok ? S_FREE_CUR : S_IDLE;
                end
            end
            S_ALLOC_CHK: begin
                priority if (w_fit) begin
                    n_state = w_split ? S_SPLIT : S_IDLE;
                end else if (w_walk_go) begin
                    n_state = S_ALLOC_CHK;
                end else begin
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                n_state = S_IDLE;
            end
            S_SPLIT: begin
                n_state = S_IDLE;
            end
            S_FREE_CUR, S_FREE_MERGE: begin
                n_state = w_more ? S_FREE_MERGE : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory control, datapath and result.
    always_comb begin
        w_rd_en    = 1'b0;
        w_rd_addr  = r_g;
        w_we       = 1'b0;
        w_wa       = r_g;
        w_wd       = '{used: 1'b1, size: SIZE_W'(r_need)};
        n_heap_end = r_heap_end;
        n_req      = r_req;
        n_need     = r_need;
        n_g        = r_g;
        n_cur      = r_cur;
        n_sz       = r_sz;
        n_done     = 1'b0;
        n_status   = r_status;
        n_addr     = r_addr;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req  = i_req;
                    n_need = w_need_in;
                end
            end
            S_START: begin
                if (r_req.req_type == REQ_ALLOC) begin
                    n_g = '0;
                    if (r_heap_end != '0) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = '0;
                    end
                end else if (w_free_ok) begin
                    n_g       = w_fg;
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_fg;
                end else begin
                    n_done   = 1'b1;
                    n_status = STATUS_OK;
                    n_addr   = '0;
                end
            end
            S_ALLOC_CHK: begin
                priority if (w_fit) begin
                    w_we = 1'b1;
                    w_wa = r_g;
                    w_wd = '{used: 1'b1, size: w_split ? SIZE_W'(r_need) : r_rd_data.size};
                    n_sz = r_rd_data.size;
                    if (!w_split) begin
                        n_done   = 1'b1;
                        n_status = STATUS_OK;
                        n_addr   = w_g_addr;
                    end
                end else if (w_walk_go) begin
                    n_g       = w_walk_next[IDX_W-1:0];
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_walk_next[IDX_W-1:0];
                end else begin
                    n_g = r_g;
                end
            end
            S_APPEND: begin
                n_done = 1'b1;
                if (w_no_space) begin
                    n_status = STATUS_NO_SPACE;
                    n_addr   = '0;
                end else begin
                    w_we       = 1'b1;
                    w_wa       = r_heap_end[IDX_W-1:0];
                    w_wd       = '{used: 1'b1, size: SIZE_W'(r_need)};
                    n_heap_end = SIZE_W'(w_end_sum);
                    n_status   = STATUS_OK;
                    n_addr     = w_end_addr;
                end
            end
            S_SPLIT: begin
                // The remainder becomes a free block right after the allocated part.
                w_we     = w_nb < (NEED_W + 1)'(HEAP_GRANULES);
                w_wa     = w_nb[IDX_W-1:0];
                w_wd     = '{used: 1'b0, size: r_sz - SIZE_W'(r_need)};
                n_done   = 1'b1;
                n_status = STATUS_OK;
                n_addr   = w_g_addr;
            end
            S_FREE_CUR, S_FREE_MERGE: begin
                n_cur = w_cur_new;
                if (w_more) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_nx[IDX_W-1:0];
                end else begin
                    w_we     = 1'b1;
                    w_wa     = r_g;
                    w_wd     = '{used: 1'b0, size: w_cur_new[SIZE_W-1:0]};
                    n_done   = 1'b1;
                    n_status = STATUS_OK;
                    n_addr   = '0;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_heap_end <= '0;
            r_limit    <= LIMIT_RESET;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_heap_end <= n_heap_end;
            r_done     <= n_done;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    // Payload state.
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_need   <= n_need;
        r_g      <= n_g;
        r_cur    <= n_cur;
        r_sz     <= n_sz;
        r_status <= n_status;
        r_addr   <= n_addr;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = '{status: r_status, data_address: r_addr};

    // An accepted transaction always occupies the block.
    `FFHA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // The result strobe comes only as the sequencer returns to idle.
    `FFHA_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_done, r_state == S_IDLE)
    // The block store is written only while a transaction is in flight.
    `FFHA_ASSERT_NOW(a_write_busy, i_clk, i_rst_n, w_we, r_state != S_IDLE)
    // A failed allocation reports address zero and leaves the heap end alone.
    `FFHA_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_done && o_result.status,
        (o_result.data_address == '0) && $stable(r_heap_end))

endmodule

@@ tb/sv/heap_alloc_checker.sv @@
// Checker for the heap allocator: tracks the heap layout, predicts each result and compares it.
module heap_alloc_checker
    import ffha_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  t_req              i_req,
    input  logic              i_done,
    input  t_result           i_result,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    output int                o_errors,
    output int                o_outstanding
);

    // Mirror of the block headers, the heap end and the heap limit register.
    logic [SIZE_W-1:0] blk_len  [HEAP_GRANULES];
    logic              blk_taken[HEAP_GRANULES];
    int unsigned       heap_top;
    logic [SIZE_W-1:0] limit_gran;
    t_result           awaited_q[$];

    // Applies one request to the mirrored heap and returns the result it must produce.
    function automatic t_result apply_request(t_req r);
        t_result     res;
        int unsigned want, g, cur, nx, cap, a;
        bit          hit;
        res = '0;
        if (r.req_type == REQ_ALLOC) begin
            want = r.request_bytes;
            want = (want + HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
            g    = 0;
            hit  = 1'b0;
            while (g < heap_top) begin
                if (!blk_taken[g] && blk_len[g] >= want) begin
                    hit = 1'b1;
                    break;
                end
                if (blk_len[g] == 0)
                    break;
                g += blk_len[g];
            end
            if (!hit) begin
                cap = (limit_gran < HEAP_GRANULES) ? limit_gran : HEAP_GRANULES;
                if (heap_top + want > cap) begin
                    res.status = STATUS_NO_SPACE;
                    return res;
                end
                g             = heap_top;
                blk_len[g]    = SIZE_W'(want);
                blk_taken[g]  = 1'b0;
                heap_top     += want;
            end
            if (blk_len[g] > want) begin
                if (g + want < HEAP_GRANULES) begin
                    blk_len[g + want]   = SIZE_W'(blk_len[g] - want);
                    blk_taken[g + want] = 1'b0;
                end
                blk_len[g] = SIZE_W'(want);
            end
            blk_taken[g]      = 1'b1;
            res.status        = STATUS_OK;
            res.data_address  = ADDR_W'(g * GRANULE_BYTES + HEADER_BYTES);
        end else begin
            a = r.free_address;
            if (a >= HEADER_BYTES && (a - HEADER_BYTES) % GRANULE_BYTES == 0) begin
                g = (a - HEADER_BYTES) / GRANULE_BYTES;
                if (g < heap_top) begin
                    // Merge only with the free blocks that follow.
                    cur = blk_len[g];
                    nx  = g + cur;
                    while (cur != 0 && nx < heap_top && !blk_taken[nx] && blk_len[nx] != 0) begin
                        cur += blk_len[nx];
                        nx   = g + cur;
                    end
                    blk_len[g]   = SIZE_W'(cur);
                    blk_taken[g] = 1'b0;
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result oldest;
        if (!i_rst_n) begin
            for (int i = 0; i < HEAP_GRANULES; i++) begin
                blk_len[i]   = '0;
                blk_taken[i] = 1'b0;
            end
            heap_top   = 0;
            limit_gran = LIMIT_RESET;
            awaited_q.delete();
            o_errors   = 0;
        end else begin
            // A result strobe belongs to an older transaction than one accepted at this edge.
            if (i_done) begin
                if (awaited_q.size() == 0) begin
                    $display("%0t: unexpected result, status %0d address %0d, expected none",
                             $time, i_result.status, i_result.data_address);
                    o_errors++;
                end else begin
                    oldest = awaited_q.pop_front();
                    if (i_result.status !== oldest.status) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, oldest.status, i_result.status);
                        o_errors++;
                    end
                    if (i_result.data_address !== oldest.data_address) begin
                        $display("%0t: data address mismatch, expected %0d actual %0d",
                                 $time, oldest.data_address, i_result.data_address);
                        o_errors++;
                    end
                end
            end
            if (i_start && !i_busy)
                awaited_q.push_back(apply_request(i_req));
            if (i_cfg_we)
                limit_gran = i_cfg_wdata;
        end
        o_outstanding = awaited_q.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for the first-fit heap allocator: clock, reset, stimulus and verdict.
module tb_top;
    import ffha_pkg::*;

    // The slowest transaction is one whose walk visits every granule of a full heap; this
    // limit leaves room for a whole run of such transactions.
    localparam int CYCLE_LIMIT = 5_000_000;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_req              i_req;
    logic              o_done;
    t_result           o_result;
    logic              i_cfg_we;
    logic [SIZE_W-1:0] i_cfg_wdata;

    int errors;
    int outstanding;
    int cycles;

    // Stimulus bookkeeping. Frees must never name a granule that was never written,
    // so trusted frees come only from addresses the block has handed out, and noise
    // frees are either misaligned, below the header size, or above the heap end.
    logic [ADDR_W-1:0] live_addrs[$];
    int unsigned       heap_mark;
    bit                alloc_in_flight;
    int unsigned       flight_need;

    first_fit_heap_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    heap_alloc_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_req         (i_req),
        .i_done        (o_done),
        .i_result      (o_result),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int unsigned granules_for(logic [BYTES_W-1:0] nbytes);
        int unsigned n;
        n = nbytes;
        return (n + HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
    endfunction

    // Harvests handed-out addresses and keeps the exact heap end as seen from outside.
    // The result of the older transaction is handled before a new acceptance at the same edge.
    always @(posedge i_clk) begin : harvest
        int unsigned g;
        if (!i_rst_n) begin
            live_addrs.delete();
            heap_mark       = 0;
            alloc_in_flight = 1'b0;
            flight_need     = 0;
        end else begin
            if (o_done) begin
                if (alloc_in_flight && o_result.status == STATUS_OK) begin
                    live_addrs.push_back(o_result.data_address);
                    g = (o_result.data_address - HEADER_BYTES) / GRANULE_BYTES;
                    if (g + flight_need > heap_mark)
                        heap_mark = g + flight_need;
                end
                alloc_in_flight = 1'b0;
            end
            if (start && !busy) begin
                alloc_in_flight = (i_req.req_type == REQ_ALLOC);
                flight_need     = granules_for(i_req.request_bytes);
            end
        end
    end

    function automatic t_req alloc_req(int unsigned nbytes);
        t_req r;
        r.req_type      = REQ_ALLOC;
        r.request_bytes = BYTES_W'(nbytes);
        r.free_address  = '0;
        return r;
    endfunction

    function automatic t_req free_req(int unsigned addr);
        t_req r;
        r.req_type      = REQ_FREE;
        r.request_bytes = '0;
        r.free_address  = ADDR_W'(addr);
        return r;
    endfunction

    // Builds one random transaction: mostly allocations and frees of live blocks, so the
    // heap fills, fragments and coalesces, with a share of frees the block must ignore.
    function automatic t_req next_request();
        t_req        r;
        int          pick;
        int          sel;
        int          k;
        int unsigned bound;
        r.req_type      = REQ_ALLOC;
        r.request_bytes = BYTES_W'($urandom_range(0, 16384));
        r.free_address  = ADDR_W'($urandom_range(0, 16383));
        pick = $urandom_range(0, 99);
        if (pick < 50 || (pick < 88 && live_addrs.size() == 0)) begin
            // Sizes are mostly small; a few requests are large enough to fail.
            sel = $urandom_range(0, 99);
            if (sel < 60)
                r.request_bytes = BYTES_W'($urandom_range(0, 64));
            else if (sel < 85)
                r.request_bytes = BYTES_W'($urandom_range(65, 400));
            else if (sel < 97)
                r.request_bytes = BYTES_W'($urandom_range(401, 4000));
            else
                r.request_bytes = BYTES_W'($urandom_range(4001, 16384));
        end else if (pick < 88) begin
            // A live block is usually retired from the list; otherwise it stays for a
            // later double free.
            r.req_type     = REQ_FREE;
            k              = $urandom_range(0, live_addrs.size() - 1);
            r.free_address = live_addrs[k];
            if ($urandom_range(0, 4) != 0)
                live_addrs.delete(k);
        end else begin
            r.req_type = REQ_FREE;
            // The transaction still in flight may append, so its size counts in the bound.
            bound = heap_mark + (alloc_in_flight ? flight_need : 0);
            if ($urandom_range(0, 1) == 0 && bound < HEAP_GRANULES) begin
                r.free_address = ADDR_W'($urandom_range(bound, HEAP_GRANULES - 1) *
                                         GRANULE_BYTES + HEADER_BYTES);
            end else if (r.free_address >= HEADER_BYTES &&
                         r.free_address[3:0] == HEADER_BYTES[3:0]) begin
                // Aligned random address inside the heap could hit a block interior.
                r.free_address[0] = 1'b1;
            end
        end
        return r;
    endfunction

    // Presents one transaction at the falling edge and holds it until accepted.
    task automatic issue(input t_req r, input bit make_random);
        @(negedge i_clk);
        if (make_random)
            r = next_request();
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic hold(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // The limit register is only written once every result has come back.
    task automatic write_limit(input logic [SIZE_W-1:0] value);
        @(negedge i_clk);
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic [SIZE_W-1:0] cap, input int count,
                             input bit back_to_back);
        int burst;
        write_limit(cap);
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 16);
                if (!back_to_back)
                    hold($urandom_range(0, 12));
            end
            issue('0, 1'b1);
            burst--;
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Smallest limit on an empty heap: one block fits exactly, the next must fail.
        write_limit(SIZE_W'(1));
        issue(free_req(0), 1'b0);       // below the header size
        issue(free_req(8), 1'b0);       // heap still empty
        issue(alloc_req(0), 1'b0);      // fills the heap to the limit
        issue(alloc_req(0), 1'b0);      // no room to append

        // A limit above the store size is clipped to the store size.
        write_limit(SIZE_W'(2047));
        issue(alloc_req(8), 1'b0);      // exactly one granule with the header
        issue(alloc_req(9), 1'b0);      // one byte over, rounds to two granules
        issue(alloc_req(16384), 1'b0);  // largest request, larger than the heap
        issue(free_req(24), 1'b0);
        issue(free_req(8), 1'b0);       // merges with the free block after it
        issue(free_req(8), 1'b0);       // freeing a block that is already free
        issue(alloc_req(0), 1'b0);      // first fit with a split of the merged block
        issue(free_req(9), 1'b0);       // misaligned address
        issue(free_req(16383), 1'b0);   // every address bit set, misaligned
        issue(free_req(16376), 1'b0);   // last granule, beyond the heap end
        issue(alloc_req(24), 1'b0);     // hole too small, walk appends at the end
        issue(free_req(40), 1'b0);
        issue(free_req(24), 1'b0);      // merge of the one-granule and two-granule holes
        issue(alloc_req(40), 1'b0);     // exact fit, no split
        issue(free_req(72), 1'b0);      // last block freed, merge stops at the heap end
        issue(alloc_req(16), 1'b0);     // reuses the freed last block
        issue(alloc_req(16368), 1'b0);  // fails by six granules

        // Random phases over a range of limits; some run back to back, some in bursts.
        run_phase(SIZE_W'(1024), 320, 1'b0);
        run_phase(SIZE_W'(1), 60, 1'b1);
        run_phase(SIZE_W'(300), 160, 1'b0);
        run_phase(SIZE_W'(2047), 160, 1'b1);
        run_phase(SIZE_W'($urandom_range(2, 1023)), 160, 1'b0);
        run_phase(SIZE_W'(64), 100, 1'b0);
        run_phase(SIZE_W'(1024), 140, 1'b1);

        // Drain, then keep the clock running for any stray strobe.
        hold(1);
        while (outstanding != 0)
            @(negedge i_clk);
        repeat (16) @(negedge i_clk);

        if (errors == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: a hang or a lost result ends the run here.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
